[rtl/brtr_pkg.sv]
// Shared types and constants for the biphase tag receiver.
package brtr_pkg;

  // Field widths
  localparam int unsigned IntervalW = 16;
  localparam int unsigned FrameW    = 64;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned RetryW    = 6;
  localparam int unsigned CountW    = 8;
  localparam int unsigned HeaderW   = 4;

  // Decoder limits
  localparam logic [CountW-1:0]  HUNT_LIMIT   = 8'd128;
  localparam logic [HeaderW-1:0] HEADER_ONES  = 4'd9;
  localparam logic [CountW-1:0]  FIRST_BIT    = 8'd9;
  localparam logic [CountW-1:0]  LAST_ROW_END = 8'd61;
  localparam logic [CountW-1:0]  FRAME_BITS   = 8'd64;
  localparam logic [2:0]         ROW_LEN      = 3'd5;
  localparam logic [FrameW-1:0]  HEADER_INIT  = 64'h1FF;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_LONG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INVERT_MODE    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_LIMIT  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT    = 2'd3;

  // Register reset values
  localparam logic [15:0]       RST_LONG_THRESHOLD = 16'd384;
  localparam logic              RST_INVERT_MODE    = 1'b0;
  localparam logic [15:0]       RST_TIMEOUT_LIMIT  = 16'd2000;
  localparam logic [RetryW-1:0] RST_RETRY_LIMIT    = 6'd30;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_COL_ERR   = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_NO_HEADER = 3'd3,
    ST_RETRY_OUT = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0]       long_threshold;
    logic              invert_mode;
    logic [15:0]       timeout_limit;
    logic [RetryW-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic              emit;
    logic [FrameW-1:0] frame;
    status_e           status;
  } result_t;

endpackage

[rtl/brtr_cfg_regs.sv]
// Configuration register file for the biphase tag receiver.
module brtr_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [brtr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [brtr_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output brtr_pkg::cfg_t                  cfg_o
);
  import brtr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LONG_THRESHOLD: cfg_d.long_threshold = cfg_wdata_i;
        CFG_INVERT_MODE:    cfg_d.invert_mode    = cfg_wdata_i[0];
        CFG_TIMEOUT_LIMIT:  cfg_d.timeout_limit  = cfg_wdata_i;
        CFG_RETRY_LIMIT:    cfg_d.retry_limit    = cfg_wdata_i[RetryW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_threshold <= RST_LONG_THRESHOLD;
      cfg_q.invert_mode    <= RST_INVERT_MODE;
      cfg_q.timeout_limit  <= RST_TIMEOUT_LIMIT;
      cfg_q.retry_limit    <= RST_RETRY_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/brtr_decoder.sv]
// Symbol classification, framing and parity checks of the tag receiver.
module brtr_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [brtr_pkg::IntervalW-1:0]    interval_i,
  input  logic                              restart_i,
  input  brtr_pkg::cfg_t                    cfg_i,
  output brtr_pkg::result_t                 res_o
);
  import brtr_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d, cur_phase;
  logic [CountW-1:0]   sc_q, sc_d, cur_sc, sc_n;
  logic [HeaderW-1:0]  ho_q, ho_d, cur_ho, ho_n;
  logic [1:0]          sp_q, sp_d, cur_sp;
  logic [FrameW-1:0]   fs_q, fs_d, cur_fs, fs_n;
  logic                rp_q, rp_d, cur_rp, rp_n;
  logic [2:0]          rb_q, rb_d, cur_rb, rb_n;
  logic [RetryW-1:0]   retry_q, retry_d, cur_retry;
  logic                is_long, pair_done, over, bit_vld, bit_val, row_end;
  result_t             res;

  // Even parity over each of the four columns, stop bit excluded.
  function automatic logic col_error(input logic [FrameW-1:0] f);
    logic err;
    logic p;
    err = 1'b0;
    for (int j = 0; j < 4; j++) begin
      p = 1'b0;
      for (int i = 0; i < 11; i++) begin
        p = p ^ f[i*5 + 1 + j];
      end
      err = err | p;
    end
    return err;
  endfunction

  // Restart wipes progress before the interval is looked at
  assign cur_phase = restart_i ? PH_HUNT : phase_q;
  assign cur_sc    = restart_i ? '0 : sc_q;
  assign cur_ho    = restart_i ? '0 : ho_q;
  assign cur_sp    = restart_i ? '0 : sp_q;
  assign cur_fs    = restart_i ? '0 : fs_q;
  assign cur_rp    = restart_i ? 1'b0 : rp_q;
  assign cur_rb    = restart_i ? '0 : rb_q;
  assign cur_retry = restart_i ? '0 : retry_q;

  assign is_long   = interval_i > cfg_i.long_threshold;
  assign pair_done = !is_long && (cur_sp != 2'd0);
  assign over      = cur_sc >= HUNT_LIMIT;
  assign bit_vld   = is_long || pair_done;
  assign bit_val   = is_long ? !cfg_i.invert_mode : cfg_i.invert_mode;
  assign fs_n      = {cur_fs[FrameW-2:0], bit_val};
  assign rp_n      = cur_rp ^ bit_val;
  assign rb_n      = cur_rb + 3'd1;
  assign sc_n      = cur_sc + 8'd1;
  assign row_end   = (rb_n == ROW_LEN) && (sc_n < LAST_ROW_END);

  always_comb begin
    ho_n = cur_ho;
    if (is_long) begin
      ho_n = cfg_i.invert_mode ? '0 : cur_ho + 4'd1;
    end else if (pair_done) begin
      ho_n = cfg_i.invert_mode ? cur_ho + 4'd1 : '0;
    end
  end

  always_comb begin
    phase_d    = cur_phase;
    sc_d       = cur_sc;
    ho_d       = cur_ho;
    sp_d       = cur_sp;
    fs_d       = cur_fs;
    rp_d       = cur_rp;
    rb_d       = cur_rb;
    retry_d    = cur_retry;
    res.emit   = 1'b0;
    res.frame  = '0;
    res.status = ST_OK;

    if (cur_phase != PH_DONE) begin
      if (interval_i > cfg_i.timeout_limit) begin
        phase_d    = PH_DONE;
        res.emit   = 1'b1;
        res.status = ST_TIMEOUT;
      end else begin
        // short pair tracking is shared by header wait and data
        if (cur_phase != PH_HUNT && !is_long) begin
          sp_d = pair_done ? 2'd0 : cur_sp + 2'd1;
        end
        unique case (cur_phase)
          PH_HUNT: begin
            if (!over) sc_d = sc_n;
            if (is_long) begin
              phase_d = PH_HEADER;
              sc_d    = '0;
            end else if (over) begin
              phase_d    = PH_DONE;
              res.emit   = 1'b1;
              res.status = ST_NO_HEADER;
            end
          end
          PH_HEADER: begin
            ho_d = ho_n;
            if (!over) sc_d = sc_n;
            if (ho_n >= HEADER_ONES) begin
              phase_d = PH_DATA;
              fs_d    = HEADER_INIT;
              sc_d    = FIRST_BIT;
              rp_d    = 1'b0;
              rb_d    = '0;
            end else if (over) begin
              phase_d    = PH_DONE;
              res.emit   = 1'b1;
              res.status = ST_NO_HEADER;
            end
          end
          PH_DATA: begin
            if (bit_vld) begin
              fs_d = fs_n;
              rp_d = rp_n;
              rb_d = rb_n;
              sc_d = sc_n;
              if (row_end && rp_n) begin
                if (cur_retry >= cfg_i.retry_limit) begin
                  phase_d    = PH_DONE;
                  res.emit   = 1'b1;
                  res.status = ST_RETRY_OUT;
                end else begin
                  // bad row: count a retry and hunt again from scratch
                  retry_d = cur_retry + 6'd1;
                  phase_d = PH_HUNT;
                  sc_d    = '0;
                  ho_d    = '0;
                  sp_d    = '0;
                  fs_d    = '0;
                  rp_d    = 1'b0;
                  rb_d    = '0;
                end
              end else if (row_end) begin
                rp_d = 1'b0;
                rb_d = '0;
              end else if (sc_n >= FRAME_BITS) begin
                phase_d  = PH_DONE;
                res.emit = 1'b1;
                if (col_error(fs_n)) begin
                  res.status = ST_COL_ERR;
                end else begin
                  res.frame = fs_n;
                end
              end
            end
          end
          PH_DONE: begin
            phase_d = cur_phase;
          end
          default: begin
            phase_d = cur_phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      sc_q    <= '0;
      ho_q    <= '0;
      sp_q    <= '0;
      fs_q    <= '0;
      rp_q    <= 1'b0;
      rb_q    <= '0;
      retry_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      sc_q    <= sc_d;
      ho_q    <= ho_d;
      sp_q    <= sp_d;
      fs_q    <= fs_d;
      rp_q    <= rp_d;
      rb_q    <= rb_d;
      retry_q <= retry_d;
    end
  end

  assign res_o = res;

`ifndef SYNTHESIS
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> (sc_q >= FIRST_BIT) && (sc_q < FRAME_BITS))
    else $error("bit count out of frame range in data phase");

  a_row_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_DONE |-> rb_q < ROW_LEN)
    else $error("row bit count passed row length");

  a_short_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= 2'd1)
    else $error("short pair count overflow");
`endif

endmodule

[rtl/biphase_rfid_tag_receiver.sv]
// Top level of the biphase tag receiver: input stage, decoder, result register.
// An accepted item waits in the input stage; its result is then held in the result register.
// Throughput: one item per cycle while no result is stalled; decoder state updates per step.
// in_stall_o rises only while a held result is stalled and the input stage is full.
// Reset (rst_ni low, async): hunt phase, all counts and retries cleared,
// registers back to threshold 384, normal mode, timeout 2000, retry limit 30.
module biphase_rfid_tag_receiver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // interval items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [brtr_pkg::IntervalW-1:0]    interval_i,
  input  logic                              restart_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [brtr_pkg::FrameW-1:0]       tag_frame_o,
  output logic [brtr_pkg::StatusW-1:0]      status_o,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [brtr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [brtr_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import brtr_pkg::*;

  cfg_t                 cfg;
  result_t              res;

  // Input stage
  logic                 s1_valid_q, s1_valid_d;
  logic [IntervalW-1:0] interval_q;
  logic                 restart_q;

  // Result register
  logic                 out_valid_q, out_valid_d;
  logic [FrameW-1:0]    frame_q;
  status_e              status_q;

  logic                 out_free, step, in_take;

  // The result register can take a new value if empty or being drained now
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  brtr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  brtr_decoder u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .interval_i (interval_q),
    .restart_i  (restart_q),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && res.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      interval_q <= interval_i;
      restart_q  <= restart_i;
    end
    if (step && res.emit) begin
      frame_q  <= res.frame;
      status_q <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tag_frame_o = frame_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_fail_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_q != ST_OK) |-> tag_frame_o == '0)
    else $error("failed read carries a nonzero frame");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tag_frame_o) && $stable(status_o))
    else $error("stalled result changed");
`endif

endmodule

[test/tb_top.sv]
// Self-checking testbench for the biphase tag receiver: interval stimulus, decode prediction, result check.
module tb_top;
  import brtr_pkg::*;

  // Run limits; the first three are counted in clock cycles, the last in items
  localparam int WATCHDOG_CYCLES = 2000;  // no handshake at all for this long ends the run
  localparam int HOLDOFF_CYCLES  = 80;    // long receiver stall that backs up the block
  localparam int TAIL_CYCLES     = 8;     // wait after the block drains; items with no result may linger
  localparam int SEND_DEPTH      = 64;    // generator stays this far ahead of the driver

  // Decoder progress in the prediction
  typedef enum logic [1:0] {
    READ_HUNT,
    READ_HEADER,
    READ_DATA,
    READ_DONE
  } read_phase_e;

  // How a generated frame gets damaged
  typedef enum int {
    FRAME_CLEAN,
    FRAME_COL_ERR,
    FRAME_ROW_ERR,
    FRAME_CUT
  } frame_fault_e;

  typedef struct {
    logic [IntervalW-1:0] interval;
    logic                 restart;
  } interval_item_t;

  typedef struct {
    logic [FrameW-1:0] frame;
    status_e           status;
  } tag_result_t;

  // Clock and reset; every input starts at a known value
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic [IntervalW-1:0] interval_i  = '0;
  logic                 restart_i   = 1'b0;
  logic                 out_stall_i = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [FrameW-1:0]    tag_frame_o;
  logic [StatusW-1:0]   status_o;

  always #2 clk_i = ~clk_i;

  biphase_rfid_tag_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .interval_i  (interval_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tag_frame_o (tag_frame_o),
    .status_o    (status_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Items waiting for the driver, and decoded reads waiting for the block's output
  interval_item_t intervals_to_send[$];
  tag_result_t    tag_results_due[$];

  // Shadow copy of the registers and of the decoder state
  cfg_t               tag_cfg;
  read_phase_e        read_phase;
  logic [CountW-1:0]  sym_cnt;
  logic [HeaderW-1:0] hdr_ones;
  logic [1:0]         pair_cnt;
  logic [FrameW-1:0]  shift_reg;
  logic               row_par;
  logic [2:0]         row_cnt;
  logic [RetryW-1:0]  retries;

  // Bookkeeping
  int  fail_cnt        = 0;
  int  items_queued    = 0;
  int  items_accepted  = 0;
  int  results_checked = 0;
  int  settings_used   = 1;
  int  idle_cycles     = 0;
  int  status_seen[5];
  bit  offer_held      = 1'b0;  // item on the input was stalled at the last edge
  int  burst_left      = 0;
  int  gap_left        = 0;
  bit  holdoff_req     = 1'b0;
  int  holdoff_left    = 0;
  bit  stall_on        = 1'b0;
  int  stall_run       = 0;

  task automatic flag_mismatch(input string what, input logic [FrameW-1:0] got,
                               input logic [FrameW-1:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    fail_cnt++;
  endtask

  // Drop all read progress; the retry count survives
  task automatic clear_read();
    read_phase = READ_HUNT;
    sym_cnt    = '0;
    hdr_ones   = '0;
    pair_cnt   = '0;
    shift_reg  = '0;
    row_par    = 1'b0;
    row_cnt    = '0;
  endtask

  // Advance the shadow decoder by one interval; emitted marks a finished read
  task automatic decode_interval(input logic [IntervalW-1:0] iv, input logic rs,
                                 output bit emitted, output tag_result_t res);
    logic is_long;
    logic over;
    logic col_bad;
    logic par;
    int   bit_v;
    int   i;
    int   j;
    emitted    = 1'b0;
    res.frame  = '0;
    res.status = ST_OK;
    bit_v      = -1;
    if (rs) begin
      clear_read();
      retries = '0;
    end
    // a finished read ignores everything until the next restart
    if (read_phase == READ_DONE) return;
    // timeout beats any other use of the interval
    if (iv > tag_cfg.timeout_limit) begin
      read_phase = READ_DONE;
      emitted    = 1'b1;
      res.status = ST_TIMEOUT;
      return;
    end
    is_long = iv > tag_cfg.long_threshold;
    case (read_phase)
      READ_HUNT: begin
        over = sym_cnt >= HUNT_LIMIT;
        if (!over) sym_cnt++;
        // a long interval wins even past the hunt limit
        if (is_long) begin
          read_phase = READ_HEADER;
          sym_cnt    = '0;
        end else if (over) begin
          read_phase = READ_DONE;
          emitted    = 1'b1;
          res.status = ST_NO_HEADER;
        end
      end
      READ_HEADER: begin
        if (is_long) begin
          hdr_ones = tag_cfg.invert_mode ? '0 : hdr_ones + 1'b1;
        end else begin
          pair_cnt++;
          if (pair_cnt >= 2'd2) begin
            pair_cnt = '0;
            hdr_ones = tag_cfg.invert_mode ? hdr_ones + 1'b1 : '0;
          end
        end
        over = sym_cnt >= HUNT_LIMIT;
        if (!over) sym_cnt++;
        // completing the header beats the limit
        if (hdr_ones >= HEADER_ONES) begin
          read_phase = READ_DATA;
          shift_reg  = HEADER_INIT;
          sym_cnt    = FIRST_BIT;
          row_par    = 1'b0;
          row_cnt    = '0;
        end else if (over) begin
          read_phase = READ_DONE;
          emitted    = 1'b1;
          res.status = ST_NO_HEADER;
        end
      end
      default: begin
        // pair count carries over from the header wait
        if (is_long) begin
          bit_v = tag_cfg.invert_mode ? 0 : 1;
        end else begin
          pair_cnt++;
          if (pair_cnt >= 2'd2) begin
            pair_cnt = '0;
            bit_v    = tag_cfg.invert_mode ? 1 : 0;
          end
        end
        if (bit_v >= 0) begin
          shift_reg = {shift_reg[FrameW-2:0], bit_v[0]};
          row_par   = row_par ^ bit_v[0];
          row_cnt++;
          sym_cnt++;
          // the column parity group at the end has no row check
          if (row_cnt == ROW_LEN && sym_cnt < LAST_ROW_END) begin
            if (row_par) begin
              if (retries >= tag_cfg.retry_limit) begin
                read_phase = READ_DONE;
                emitted    = 1'b1;
                res.status = ST_RETRY_OUT;
                return;
              end
              retries++;
              clear_read();
              return;
            end
            row_par = 1'b0;
            row_cnt = '0;
          end
          if (sym_cnt >= FRAME_BITS) begin
            col_bad = 1'b0;
            for (j = 0; j < 4; j++) begin
              par = shift_reg[1+j];
              for (i = 1; i < 11; i++) par = par ^ shift_reg[i*5+1+j];
              col_bad = col_bad | par;
            end
            read_phase = READ_DONE;
            emitted    = 1'b1;
            if (col_bad) begin
              res.status = ST_COL_ERR;
            end else begin
              res.frame  = shift_reg;
              res.status = ST_OK;
            end
          end
        end
      end
    endcase
  endtask

  // Input driver: bursts of items separated by gaps, payload held while stalled
  always @(negedge clk_i) begin
    if (!offer_held) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (intervals_to_send.size() > 0) begin
        in_valid_i <= 1'b1;
        interval_i <= intervals_to_send[0].interval;
        restart_i  <= intervals_to_send[0].restart;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // now and then a long burst without any gap
          if ($urandom_range(3, 0) == 0) begin
            burst_left = $urandom_range(120, 40);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(16, 1);
            gap_left   = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall: alternating stall and free runs, plus a requested long hold-off
  always @(negedge clk_i) begin
    if (holdoff_req) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_req  = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_on  = !stall_on;
        stall_run = stall_on ? $urandom_range(6, 1) :
                    ($urandom_range(7, 0) == 0) ? $urandom_range(200, 50) : $urandom_range(12, 1);
      end
      stall_run--;
      out_stall_i <= stall_on;
    end
  end

  // Monitor: predict on each accepted interval, check each accepted result, watchdog
  always @(posedge clk_i) begin : monitor
    interval_item_t item;
    tag_result_t    decoded;
    tag_result_t    want;
    bit             got;
    bit             busy;
    if (rst_ni) begin
      busy = cfg_we_i;
      if (in_valid_i && !in_stall_o) begin
        item = intervals_to_send.pop_front();
        decode_interval(item.interval, item.restart, got, decoded);
        if (got) tag_results_due.push_back(decoded);
        items_accepted++;
        busy = 1'b1;
      end
      offer_held = in_valid_i && in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        busy = 1'b1;
        results_checked++;
        if (tag_results_due.size() == 0) begin
          flag_mismatch("result with no read pending", tag_frame_o, '0);
        end else begin
          want = tag_results_due.pop_front();
          status_seen[int'(want.status)]++;
          if (tag_frame_o !== want.frame) flag_mismatch("tag_frame", tag_frame_o, want.frame);
          if (status_o !== want.status)
            flag_mismatch("status", FrameW'(status_o), FrameW'(want.status));
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_CYCLES);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---- stimulus helpers ----

  task automatic send(input logic [IntervalW-1:0] iv, input logic rs);
    while (intervals_to_send.size() >= SEND_DEPTH) @(negedge clk_i);
    intervals_to_send.push_back('{iv, rs});
    items_queued++;
  endtask

  // Interval that is short and not a timeout; boundaries favored
  function automatic logic [IntervalW-1:0] short_iv();
    int hi;
    hi = (tag_cfg.long_threshold < tag_cfg.timeout_limit) ?
         tag_cfg.long_threshold : tag_cfg.timeout_limit;
    case ($urandom_range(7, 0))
      0:       return IntervalW'(hi);
      1:       return '0;
      default: return IntervalW'($urandom_range(hi, 0));
    endcase
  endfunction

  // Interval that is long and not a timeout, where the settings allow one
  function automatic logic [IntervalW-1:0] long_iv();
    int lo;
    int hi;
    hi = tag_cfg.timeout_limit;
    if (tag_cfg.long_threshold >= tag_cfg.timeout_limit) return IntervalW'(hi);
    lo = tag_cfg.long_threshold + 1;
    case ($urandom_range(7, 0))
      0:       return IntervalW'(lo);
      1:       return IntervalW'(hi);
      default: return IntervalW'($urandom_range(hi, lo));
    endcase
  endfunction

  // Interval above the timeout limit; with the limit at full scale none exists
  function automatic logic [IntervalW-1:0] timeout_iv();
    int lo;
    if (tag_cfg.timeout_limit == 16'hFFFF) return 16'hFFFF;
    lo = tag_cfg.timeout_limit + 1;
    case ($urandom_range(2, 0))
      0:       return IntervalW'(lo);
      1:       return 16'hFFFF;
      default: return IntervalW'($urandom_range(65535, lo));
    endcase
  endfunction

  // One biphase bit: long carries a one in normal mode, a zero when inverted
  task automatic put_bit(input logic b);
    if (b ^ tag_cfg.invert_mode) begin
      send(long_iv(), 1'b0);
    end else begin
      send(short_iv(), 1'b0);
      send(short_iv(), 1'b0);
    end
  endtask

  // Hunt long plus nine header ones, sometimes after a false start
  task automatic send_preamble(input logic rs);
    int lead;
    lead = $urandom_range(2, 0);
    repeat (lead) begin
      send(short_iv(), rs);
      rs = 1'b0;
    end
    send(long_iv(), rs);
    if ($urandom_range(5, 0) == 0) begin
      put_bit(1'b1);
      put_bit(1'b1);
      put_bit(1'b0);
    end
    repeat (9) put_bit(1'b1);
  endtask

  // 10 rows of 4 data bits with even row parity, column parity, stop bit
  task automatic send_frame(input frame_fault_e fault);
    logic [39:0] data;
    logic [54:0] bits;
    logic [3:0]  nib;
    logic [3:0]  col;
    int          k;
    int          r;
    int          bad_row;
    int          cut_at;
    data[31:0]  = $urandom;
    data[39:32] = 8'($urandom_range(255, 0));
    bad_row     = $urandom_range(9, 0);
    col         = '0;
    k           = 54;
    for (r = 0; r < 10; r++) begin
      nib           = data[r*4 +: 4];
      bits[k -: 4]  = nib;
      bits[k-4]     = (^nib) ^ (fault == FRAME_ROW_ERR && r == bad_row);
      col           = col ^ nib;
      k             = k - 5;
    end
    if (fault == FRAME_COL_ERR) col = col ^ (4'b0001 << $urandom_range(3, 0));
    bits[4:1] = col;
    bits[0]   = 1'($urandom_range(1, 0));
    cut_at    = (fault == FRAME_CUT) ? $urandom_range(54, 0) : -1;
    for (k = 54; k >= 0; k--) begin
      if (k == cut_at) send(timeout_iv(), 1'b0);
      put_bit(bits[k]);
    end
  endtask

  // One read attempt: mostly frames, some of them damaged, the rest noise or limit runs
  task automatic one_read();
    int           kind;
    int           c;
    frame_fault_e fault;
    kind = $urandom_range(99, 0);
    if (kind < 60) begin
      fault = (kind < 30) ? FRAME_CLEAN :
              (kind < 38) ? FRAME_COL_ERR :
              (kind < 50) ? FRAME_ROW_ERR : FRAME_CUT;
      send_preamble(1'b1);
      send_frame(fault);
      // a row error restarts the hunt; follow with a good copy
      if (fault == FRAME_ROW_ERR) begin
        send_preamble(1'b0);
        send_frame(FRAME_CLEAN);
      end
    end else if (kind < 75) begin
      repeat ($urandom_range(30, 5)) begin
        c = $urandom_range(19, 0);
        if (c == 0)       send(timeout_iv(), 1'($urandom_range(1, 0)));
        else if (c < 3)   send(IntervalW'($urandom_range(65535, 0)), 1'($urandom_range(1, 0)));
        else if (c < 10)  send(long_iv(), 1'b0);
        else              send(short_iv(), 1'b0);
      end
    end else if (kind < 88) begin
      // hunt with no long interval, around the limit
      send(short_iv(), 1'b1);
      repeat ($urandom_range(131, 125)) send(short_iv(), 1'b0);
      if ($urandom_range(1, 0)) send(long_iv(), 1'b0);
    end else begin
      // header wait that never sees enough ones in a row
      send(long_iv(), 1'b1);
      repeat ($urandom_range(50, 40)) begin
        put_bit(1'b1);
        put_bit(1'b0);
      end
    end
  endtask

  task automatic run_reads(input int n);
    int target;
    target = items_queued + n;
    while (items_queued < target) one_read();
  endtask

  // Wait until every item is taken and every decoded read has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (intervals_to_send.size() != 0 || tag_results_due.size() != 0 || in_valid_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_LONG_THRESHOLD: tag_cfg.long_threshold = val;
      CFG_INVERT_MODE:    tag_cfg.invert_mode    = val[0];
      CFG_TIMEOUT_LIMIT:  tag_cfg.timeout_limit  = val;
      CFG_RETRY_LIMIT:    tag_cfg.retry_limit    = val[RetryW-1:0];
      default: ;
    endcase
  endtask

  // Registers change only with the block drained
  task automatic apply_setting(input int thr, input int inv, input int tmo, input int rlim);
    wait_idle();
    write_reg(CFG_LONG_THRESHOLD, CfgDataW'(thr));
    write_reg(CFG_INVERT_MODE, CfgDataW'(inv));
    write_reg(CFG_TIMEOUT_LIMIT, CfgDataW'(tmo));
    write_reg(CFG_RETRY_LIMIT, CfgDataW'(rlim));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // ---- test sequence ----
  initial begin : sequencer
    int round;
    int thr;
    foreach (status_seen[s]) status_seen[s] = 0;
    tag_cfg.long_threshold = RST_LONG_THRESHOLD;
    tag_cfg.invert_mode    = RST_INVERT_MODE;
    tag_cfg.timeout_limit  = RST_TIMEOUT_LIMIT;
    tag_cfg.retry_limit    = RST_RETRY_LIMIT;
    clear_read();
    retries = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, threshold and timeout edges, ignore after done
    send(16'd0, 1'b1);       // short in the hunt
    send(16'hFFFF, 1'b0);    // timeout
    send(16'd100, 1'b0);     // ignored, read finished
    send(16'd384, 1'b1);     // equal to threshold: still short
    send(16'd385, 1'b0);     // just long: into header wait
    send(16'd2000, 1'b0);    // at the limit: long, not a timeout
    send(16'd2001, 1'b0);    // just over the limit
    send(16'd1, 1'b0);       // ignored
    send(16'hFFFF, 1'b1);    // restart and time out at once
    send(16'd0, 1'b0);       // ignored

    // Reset settings
    run_reads(150);

    // Back-pressure: every item finishes a read while the output is held off
    wait_idle();
    holdoff_req = 1'b1;
    repeat (24) send(timeout_iv(), 1'b1);

    // Inverted, no retries tolerated
    apply_setting(384, 1, 2000, 0);
    run_reads(150);
    // Zero threshold, no timeout possible, most retries
    apply_setting(0, 0, 65535, 63);
    run_reads(150);
    // Nothing can be long: only hunt failures
    apply_setting(65535, 1, 65535, 1);
    run_reads(150);
    // Everything but zero times out
    apply_setting(0, 1, 0, 63);
    run_reads(40);

    // Random settings until enough items and reads have gone through, for at most 16 rounds
    for (round = 0; round < 16 && (items_accepted < 900 || results_checked < 48); round++) begin
      thr = $urandom_range(2000, 1);
      apply_setting(thr, $urandom_range(1, 0), thr + $urandom_range(4000, 1),
                    ($urandom_range(3, 0) == 0) ? $urandom_range(63, 0) : $urandom_range(2, 0));
      run_reads(300);
    end

    wait_idle();
    repeat (2 * TAIL_CYCLES) @(posedge clk_i);
    if (tag_results_due.size() != 0)
      flag_mismatch("reads never delivered", FrameW'(tag_results_due.size()), '0);

    $display("covered %0d interval items and %0d finished reads over %0d register settings",
             items_accepted, results_checked, settings_used);
    $display("reads by outcome: ok %0d, column parity %0d, timeout %0d, no header %0d, retries out %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/brtr_pkg.sv
rtl/brtr_cfg_regs.sv
rtl/brtr_decoder.sv
rtl/biphase_rfid_tag_receiver.sv
test/tb_top.sv
